// File: sv/rsra_pkg.sv
// Shared types and constants for the Reynolds stress running average unit.
// Used by rsra_div, rsra_lane, reynolds_stress_running_average_unit and tb_top; no dependencies.
package rsra_pkg;

    localparam int NUM_CELLS   = 4096;
    localparam int CELL_W      = $clog2(NUM_CELLS);
    localparam int LANES       = 6;
    localparam int VEL_W       = 16;
    localparam int WORD_W      = 32;
    localparam int DIV_STAGES  = WORD_W + 1;
    localparam int PIPE_DEPTH  = 3 + DIV_STAGES;
    localparam int IN_FIELDS_W = 12 + 6 * VEL_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * LANES * WORD_W;

    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_FILTER_WIDTH    = 2'd0;
    localparam reg_index_t REG_SAMPLE_INTERVAL = 2'd1;
    localparam reg_index_t REG_ELAPSED_TIME    = 2'd2;

    typedef logic [1:0] comp_idx_t;
    // Velocity components feeding each lane: xx, xy, xz, yy, yz, zz.
    localparam comp_idx_t LANE_A [LANES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam comp_idx_t LANE_B [LANES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    typedef struct packed {
        logic [WORD_W-1:0] flt;
        logic [WORD_W-1:0] fac;
        logic [WORD_W-1:0] ivl;
        logic              flt_zero;
    } avg_cfg_t;

    typedef struct packed {
        logic adv;
        logic rd_en;
        logic wr_en;
        logic clear;
    } lane_ctrl_t;

endpackage

// File: sv/rsra_div.sv
// Pipelined restoring divider, one quotient bit per stage, 64-bit dividend by 32-bit divisor.
// Depends on rsra_pkg; quotient bit 32 flags a quotient of 2^32 or more.
module rsra_div (
    input  logic                          aclk,
    input  logic                          adv,
    input  logic [2*rsra_pkg::WORD_W-1:0] dividend,
    input  logic [rsra_pkg::WORD_W-1:0]   divisor,
    output logic [rsra_pkg::WORD_W:0]     quotient
);

    logic [2*rsra_pkg::WORD_W-1:0] rem_reg [rsra_pkg::DIV_STAGES];
    logic [rsra_pkg::WORD_W:0]     q_reg   [rsra_pkg::DIV_STAGES];

    for (genvar i = 0; i < rsra_pkg::DIV_STAGES; i++) begin : g_stage
        localparam int J = rsra_pkg::DIV_STAGES - 1 - i;
        logic [2*rsra_pkg::WORD_W-1:0] rem_in;
        logic [rsra_pkg::WORD_W:0]     q_in;
        logic [2*rsra_pkg::WORD_W-1:0] dshift;
        logic                          take;

        if (i == 0) begin : g_first
            assign rem_in = dividend;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        assign dshift = {{rsra_pkg::WORD_W{1'b0}}, divisor} << J;
        assign take   = rem_in >= dshift;

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[i] <= take ? rem_in - dshift : rem_in;
                q_reg[i]   <= q_in | ((rsra_pkg::WORD_W+1)'(take) << J);
            end
        end
    end

    assign quotient = q_reg[rsra_pkg::DIV_STAGES-1];

endmodule

// File: sv/rsra_lane.sv
// One product lane: per-cell stress memory, weighted blend, division, saturation.
// Depends on rsra_pkg and rsra_div.
module rsra_lane (
    input  logic                              aclk,
    input  rsra_pkg::lane_ctrl_t              ctrl,
    input  rsra_pkg::avg_cfg_t                cfg,
    input  logic [rsra_pkg::CELL_W-1:0]       rd_addr,
    input  logic [rsra_pkg::CELL_W-1:0]       wr_addr,
    input  logic signed [rsra_pkg::WORD_W-1:0] prod_in,
    input  logic signed [rsra_pkg::WORD_W-1:0] mprod_in,
    output logic signed [rsra_pkg::WORD_W-1:0] stress,
    output logic signed [rsra_pkg::WORD_W-1:0] fluct
);

    localparam int W  = rsra_pkg::WORD_W;
    localparam int DS = rsra_pkg::DIV_STAGES;

    logic signed [W-1:0] mem [rsra_pkg::NUM_CELLS];
    logic signed [W-1:0] old1_reg;

    logic signed [W-1:0] prod1_reg, mprod1_reg;
    logic [2*W-1:0]      a2_reg, b2_reg;
    logic                an2_reg, bn2_reg;
    logic signed [W-1:0] old2_reg, mprod2_reg;
    logic [2*W-1:0]      m3_reg;
    logic                neg3_reg;
    logic signed [W-1:0] old3_reg, mprod3_reg;
    logic                neg_d_reg   [DS];
    logic signed [W-1:0] old_d_reg   [DS];
    logic signed [W-1:0] mprod_d_reg [DS];

    logic [W-1:0]        mag_old, mag_prod;
    logic [2*W-1:0]      m_next;
    logic                neg_next;
    logic [W:0]          q;
    logic signed [W-1:0] s_calc;
    logic signed [W:0]   diff;

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            old1_reg <= mem[rd_addr];
        end
        if (ctrl.wr_en) begin
            mem[wr_addr] <= ctrl.clear ? '0 : stress;
        end
    end

    assign mag_old  = old1_reg[W-1]  ? W'(-old1_reg)  : W'(old1_reg);
    assign mag_prod = prod1_reg[W-1] ? W'(-prod1_reg) : W'(prod1_reg);

    always_comb begin
        if (an2_reg == bn2_reg) begin
            m_next   = a2_reg + b2_reg;
            neg_next = an2_reg;
        end else if (a2_reg >= b2_reg) begin
            m_next   = a2_reg - b2_reg;
            neg_next = an2_reg;
        end else begin
            m_next   = b2_reg - a2_reg;
            neg_next = bn2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            prod1_reg  <= prod_in;
            mprod1_reg <= mprod_in;
            a2_reg     <= (2*W)'(mag_old)  * (2*W)'(cfg.fac);
            b2_reg     <= (2*W)'(mag_prod) * (2*W)'(cfg.ivl);
            an2_reg    <= old1_reg[W-1];
            bn2_reg    <= prod1_reg[W-1];
            old2_reg   <= old1_reg;
            mprod2_reg <= mprod1_reg;
            m3_reg     <= m_next;
            neg3_reg   <= neg_next;
            old3_reg   <= old2_reg;
            mprod3_reg <= mprod2_reg;
            neg_d_reg[0]   <= neg3_reg;
            old_d_reg[0]   <= old3_reg;
            mprod_d_reg[0] <= mprod3_reg;
            for (int i = 1; i < DS; i++) begin
                neg_d_reg[i]   <= neg_d_reg[i-1];
                old_d_reg[i]   <= old_d_reg[i-1];
                mprod_d_reg[i] <= mprod_d_reg[i-1];
            end
        end
    end

    rsra_div u_div (
        .aclk     (aclk),
        .adv      (ctrl.adv),
        .dividend (m3_reg),
        .divisor  (cfg.flt),
        .quotient (q)
    );

    // Saturate the quotient to the signed word range.
    always_comb begin
        if (neg_d_reg[DS-1]) begin
            if (q[W] || q[W-1]) s_calc = {1'b1, {(W-1){1'b0}}};
            else                s_calc = W'(-$signed(q[W-1:0]));
        end else begin
            if (q[W] || q[W-1]) s_calc = {1'b0, {(W-1){1'b1}}};
            else                s_calc = q[W-1:0];
        end
    end

    assign stress = cfg.flt_zero ? old_d_reg[DS-1] : s_calc;
    assign diff   = (W+1)'(stress) - (W+1)'(mprod_d_reg[DS-1]);

    always_comb begin
        if (diff[W] != diff[W-1]) begin
            fluct = diff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            fluct = diff[W-1:0];
        end
    end

endmodule

// File: sv/reynolds_stress_running_average_unit.sv
// Top level of the Reynolds stress running average unit: input decode, lane control,
// hazard check, memory clearing and output register. Depends on rsra_pkg and rsra_lane.
//
// The unit takes one cell word per clock while s_tready is high and returns one result
// word per cell, in order. Each of the six velocity products runs in its own lane with a
// 4096-entry stress memory, two 32x32 multipliers and a 33-stage pipelined divider; the
// output register merges the lanes into one word. A cell whose previous update is still
// inside the pipeline holds s_tready low until that update has been written back, so
// repeated hits on one cell wait for each update to pass through the whole pipeline, while
// distinct cells run at one word per cycle when the output does not stall. After reset a
// clearing pass zeroes every entry of the stress memories, during which
// s_tready is low; configuration writes are taken at any time and must only be issued
// while the unit is idle.
module reynolds_stress_running_average_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cell_index, vel_x, vel_y, vel_z, mean_x, mean_y, mean_z, zero pad (lowest first)
    input  logic [rsra_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // stress_xx, xy, xz, yy, yz, zz, fluct_xx, xy, xz, yy, yz, zz (lowest first)
    output logic [rsra_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_wr_en,
    input  rsra_pkg::reg_index_t             cfg_wr_index,
    input  logic [rsra_pkg::WORD_W-1:0]      cfg_wr_data
);

    localparam int W  = rsra_pkg::WORD_W;
    localparam int PD = rsra_pkg::PIPE_DEPTH;
    localparam int CW = rsra_pkg::CELL_W;
    localparam int VW = rsra_pkg::VEL_W;

    // Configuration registers and the derived filter terms.
    logic [W-1:0] filter_width_reg, sample_interval_reg, elapsed_time_reg;
    rsra_pkg::avg_cfg_t cfg_reg, cfg_next;
    logic [W-1:0] lo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_width_reg    <= '0;
            sample_interval_reg <= W'(65536);
            elapsed_time_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                rsra_pkg::REG_FILTER_WIDTH:    filter_width_reg    <= cfg_wr_data;
                rsra_pkg::REG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_wr_data;
                rsra_pkg::REG_ELAPSED_TIME:    elapsed_time_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // The filter is clamped below by the sample interval, so the factor never goes negative.
    always_comb begin
        lo = (filter_width_reg < elapsed_time_reg) ? filter_width_reg : elapsed_time_reg;
        cfg_next.flt      = (lo > sample_interval_reg) ? lo : sample_interval_reg;
        cfg_next.fac      = cfg_next.flt - sample_interval_reg;
        cfg_next.ivl      = sample_interval_reg;
        cfg_next.flt_zero = cfg_next.flt == '0;
    end

    always_ff @(posedge aclk) begin
        cfg_reg <= cfg_next;
    end

    // Clearing pass over the stress memories after reset.
    logic [CW-1:0] clr_cnt_reg;
    logic          clear_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            clear_done_reg <= 1'b0;
        end else if (!clear_done_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CW'(rsra_pkg::NUM_CELLS - 1)) begin
                clear_done_reg <= 1'b1;
            end
        end
    end

    // Input decode and the 16x16 products for every lane.
    logic [CW-1:0]          in_cell;
    logic signed [VW-1:0]   vel  [3];
    logic signed [VW-1:0]   mean [3];
    logic signed [W-1:0]    prod  [rsra_pkg::LANES];
    logic signed [W-1:0]    mprod [rsra_pkg::LANES];

    assign in_cell = s_tdata[CW-1:0];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            vel[c]  = s_tdata[12 + c*VW +: VW];
            mean[c] = s_tdata[12 + (3 + c)*VW +: VW];
        end
        for (int l = 0; l < rsra_pkg::LANES; l++) begin
            prod[l]  = vel[rsra_pkg::LANE_A[l]]  * vel[rsra_pkg::LANE_B[l]];
            mprod[l] = mean[rsra_pkg::LANE_A[l]] * mean[rsra_pkg::LANE_B[l]];
        end
    end

    // Pipeline occupancy: one valid bit and one cell index per stage.
    logic [PD-1:0] valid_reg;
    logic [CW-1:0] cell_reg [PD];
    logic          out_valid_reg;
    logic          adv, hazard, accept;

    assign adv = !out_valid_reg || m_tready;

    // A cell still in flight has not yet written its new stress back.
    always_comb begin
        hazard = 1'b0;
        for (int i = 0; i < PD; i++) begin
            if (valid_reg[i] && cell_reg[i] == in_cell) hazard = 1'b1;
        end
    end

    assign s_tready = clear_done_reg && adv && !hazard;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg     <= {valid_reg[PD-2:0], accept};
            out_valid_reg <= valid_reg[PD-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cell_reg[0] <= in_cell;
            for (int i = 1; i < PD; i++) begin
                cell_reg[i] <= cell_reg[i-1];
            end
        end
    end

    // Lanes.
    rsra_pkg::lane_ctrl_t lane_ctrl;
    logic [CW-1:0]        wr_addr;
    logic signed [W-1:0]  stress [rsra_pkg::LANES];
    logic signed [W-1:0]  fluct  [rsra_pkg::LANES];

    always_comb begin
        lane_ctrl.adv   = adv;
        lane_ctrl.rd_en = accept;
        lane_ctrl.clear = !clear_done_reg;
        lane_ctrl.wr_en = !clear_done_reg || (adv && valid_reg[PD-1]);
        wr_addr         = clear_done_reg ? cell_reg[PD-1] : clr_cnt_reg;
    end

    for (genvar l = 0; l < rsra_pkg::LANES; l++) begin : g_lane
        rsra_lane u_lane (
            .aclk     (aclk),
            .ctrl     (lane_ctrl),
            .cfg      (cfg_reg),
            .rd_addr  (in_cell),
            .wr_addr  (wr_addr),
            .prod_in  (prod[l]),
            .mprod_in (mprod[l]),
            .stress   (stress[l]),
            .fluct    (fluct[l])
        );
    end

    // Output register merges the six lanes into one result word.
    logic [rsra_pkg::OUT_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (adv && valid_reg[PD-1]) begin
            for (int l = 0; l < rsra_pkg::LANES; l++) begin
                out_data_reg[l*W +: W]                    <= stress[l];
                out_data_reg[(rsra_pkg::LANES + l)*W +: W] <= fluct[l];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The pipeline stays empty while the memories are being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_done_reg |-> (valid_reg == '0 && !out_valid_reg))
        else $error("pipeline busy during clearing pass");

    // A cell being read never coincides with a write back of that same cell.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && valid_reg[PD-1]) |-> (cell_reg[PD-1] != in_cell))
        else $error("read of a cell whose update is not written back");

    // A finished word held by a stall stays in the last stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[PD-1] && !adv) |=> valid_reg[PD-1])
        else $error("result lost while stalled");

    // Every word leaving the last stage lands in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[PD-1] && adv) |=> out_valid_reg)
        else $error("result not captured in output register");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for reynolds_stress_running_average_unit.
// Drives cell words through a stream port and checks each stress/fluctuation word
// against a behavioral predictor kept here; depends on rsra_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY   = 36;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 500;

    typedef struct packed {
        logic [11:0]       cell_idx;
        logic signed [15:0] vx, vy, vz, mx, my, mz;
    } cell_word_t;

    typedef struct {
        logic signed [31:0] st [6];
        logic signed [31:0] fl [6];
    } stress_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [rsra_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rsra_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    rsra_pkg::reg_index_t cfg_wr_index = rsra_pkg::REG_FILTER_WIDTH;
    logic [rsra_pkg::WORD_W-1:0] cfg_wr_data = '0;

    reynolds_stress_running_average_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state: a copy of the registers and the per-cell stress store.
    logic [31:0] win_reg, ivl_reg, elap_reg;
    logic signed [31:0] stress_mem [rsra_pkg::NUM_CELLS*6];

    cell_word_t   pending_words[$];
    stress_word_t expected_stress[$];
    int errors = 0;
    int wdog = 0;

    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Weighted running average with exact sum, truncation toward zero and saturation.
    function automatic logic signed [31:0] average_step(logic signed [63:0] old_s,
            logic [31:0] fac, logic signed [63:0] prod, logic [31:0] ivl, logic [31:0] flt);
        logic [63:0] a, b, m;
        bit an, bn, neg;
        an = old_s < 0;
        bn = prod < 0;
        a = (an ? -old_s : old_s) * {32'd0, fac};
        b = (bn ? -prod : prod) * {32'd0, ivl};
        if (an == bn) begin
            m = a + b; neg = an;
        end else if (a >= b) begin
            m = a - b; neg = an;
        end else begin
            m = b - a; neg = bn;
        end
        m = m / {32'd0, flt};
        if (neg) return (m >= 64'h80000000) ? 32'sh80000000 : -$signed(m[31:0]);
        return (m > 64'h7fffffff) ? 32'sh7fffffff : m[31:0];
    endfunction

    function automatic stress_word_t predict_stress(cell_word_t w);
        stress_word_t r;
        logic signed [63:0] u [3], mu [3];
        logic [31:0] lo, flt, fac;
        int k, base;
        u[0] = w.vx; u[1] = w.vy; u[2] = w.vz;
        mu[0] = w.mx; mu[1] = w.my; mu[2] = w.mz;
        lo  = (win_reg < elap_reg) ? win_reg : elap_reg;
        flt = (lo > ivl_reg) ? lo : ivl_reg;
        fac = flt - ivl_reg;
        base = (w.cell_idx % rsra_pkg::NUM_CELLS) * 6;
        for (k = 0; k < rsra_pkg::LANES; k++) begin
            logic signed [31:0] s;
            s = stress_mem[base+k];
            if (flt != 0)
                s = average_step(s, fac,
                    u[rsra_pkg::LANE_A[k]] * u[rsra_pkg::LANE_B[k]], ivl_reg, flt);
            stress_mem[base+k] = s;
            r.st[k] = s;
            r.fl[k] = sat32(64'(s) - mu[rsra_pkg::LANE_A[k]] * mu[rsra_pkg::LANE_B[k]]);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // Driver: takes one pending word per handshake, with random gaps.
    int s_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_stress.push_back(predict_stress(pending_words.pop_front()));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    // The head of the queue is the next word to present.
                    s_tvalid <= 1'b1;
                    s_tdata <= rsra_pkg::IN_TDATA_W'({pending_words[0].mz,
                        pending_words[0].my,
                        pending_words[0].mx,
                        pending_words[0].vz,
                        pending_words[0].vy,
                        pending_words[0].vx,
                        pending_words[0].cell_idx});
                    s_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result word with the oldest expectation.
    int m_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (m_tvalid && m_tready) begin
                if (expected_stress.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_tdata);
                    errors++;
                end else begin
                    stress_word_t e;
                    e = expected_stress.pop_front();
                    for (int k = 0; k < rsra_pkg::LANES; k++) begin
                        if (m_tdata[32*k +: 32] !== e.st[k]) begin
                            $display("%0t: stress lane %0d expected %h actual %h",
                                $time, k, e.st[k], m_tdata[32*k +: 32]);
                            errors++;
                        end
                        if (m_tdata[32*(k+6) +: 32] !== e.fl[k]) begin
                            $display("%0t: fluct lane %0d expected %h actual %h",
                                $time, k, e.fl[k], m_tdata[32*(k+6) +: 32]);
                            errors++;
                        end
                    end
                end
            end
            // Result-side stalls: mostly short, now and then long.
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(99) < 20) m_gap <= pick_gap();
            end
            if (wdog >= WDOG_MAX) begin
                $display("** reynolds_stress_running_average_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic cell_word_t rand_word(int cell_hi, bit hot);
        cell_word_t w;
        w.cell_idx = hot ? 12'($urandom_range(7)) : 12'($urandom_range(cell_hi));
        w.vx = 16'($urandom); w.vy = 16'($urandom); w.vz = 16'($urandom);
        w.mx = 16'($urandom); w.my = 16'($urandom); w.mz = 16'($urandom);
        return w;
    endfunction

    // Register writes happen only after the pipeline has fully drained.
    task automatic write_reg(rsra_pkg::reg_index_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == rsra_pkg::REG_FILTER_WIDTH) win_reg = val;
        else if (idx == rsra_pkg::REG_SAMPLE_INTERVAL) ivl_reg = val;
        else elap_reg = val;
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !s_tvalid && expected_stress.size() == 0);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_timing(logic [31:0] w, logic [31:0] i, logic [31:0] e);
        write_reg(rsra_pkg::REG_FILTER_WIDTH, w);
        write_reg(rsra_pkg::REG_SAMPLE_INTERVAL, i);
        write_reg(rsra_pkg::REG_ELAPSED_TIME, e);
    endtask

    initial begin
        cell_word_t w;
        win_reg = 0; ivl_reg = 32'd65536; elap_reg = 0;
        for (int i = 0; i < rsra_pkg::NUM_CELLS*6; i++) stress_mem[i] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset timing (filter equals interval), extreme velocities, same cell.
        w = '{12'd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
        pending_words.push_back(w);
        w = '{12'd4095, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        pending_words.push_back(w);
        w = '{12'd0, 16'sh0000, 16'sh0001, 16'shffff, 16'sh8000, 16'sh8000, 16'sh8000};
        pending_words.push_back(w);
        pending_words.push_back(w);
        drain();
        // Zero filter: stress stays unchanged.
        set_timing(32'd0, 32'd0, 32'd0);
        pending_words.push_back(rand_word(3, 0));
        pending_words.push_back(rand_word(3, 0));
        drain();
        // Maximum window and elapsed time with a tiny interval.
        set_timing(32'hffffffff, 32'd1, 32'hffffffff);
        for (int i = 0; i < 6; i++) pending_words.push_back(rand_word(3, 0));
        drain();
        // Maximum interval: filter equals interval, factor zero.
        set_timing(32'd100, 32'hffffffff, 32'd5);
        for (int i = 0; i < 4; i++) pending_words.push_back(rand_word(4095, 0));
        drain();

        // Random phases with random timing settings; half of the words hit a few hot cells.
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(3))
                0: set_timing($urandom, $urandom, $urandom);
                1: set_timing(32'($urandom_range(20, 1)) << 16, 32'd65536,
                              32'($urandom_range(20)) << 16);
                2: set_timing($urandom_range(1 << 20), $urandom_range(1 << 16),
                              $urandom_range(1 << 20));
                default: set_timing(32'hffffffff, $urandom_range(3), $urandom);
            endcase
            for (int i = 0; i < N_RANDOM / 10; i++)
                pending_words.push_back(rand_word(4095, 1'($urandom_range(1))));
            drain();
        end

        if (errors == 0) begin
            $display("** reynolds_stress_running_average_unit: PASSED **");
        end else begin
            $display("** reynolds_stress_running_average_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
sv/rsra_pkg.sv
sv/rsra_div.sv
sv/rsra_lane.sv
sv/reynolds_stress_running_average_unit.sv
test/tb_top.sv
